// File: sv/stp_pkg.sv
`default_nettype none
package stp_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int ACT_W    = 3;
  localparam int ID_W     = 4;
  localparam int TICKS_W  = 32;
  localparam int HANDLE_W = 4;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [ACT_W-1:0] ACT_REQUEST = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RELOAD  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CHECK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_TICK    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_COUNTING = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXPIRED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd2;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EXEC,
    CMD_SCAN,
    CMD_CHECK,
    CMD_TICK,
    CMD_PUBLISH
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             hit;
    logic             last;
  } sts_t;

endpackage
`default_nettype wire

// File: sv/stp_ctrl.sv
`default_nettype none
module stp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire stp_pkg::sts_t sts,
  output stp_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_CHK,
    S_TICK,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = stp_pkg::CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = stp_pkg::CMD_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd = stp_pkg::CMD_EXEC;
        unique case (sts.act)
          stp_pkg::ACT_REQUEST: state_nxt = S_SCAN;
          stp_pkg::ACT_CHECK:   state_nxt = S_CHK;
          stp_pkg::ACT_TICK:    state_nxt = S_TICK;
          default:              state_nxt = S_FINISH;
        endcase
      end
      S_SCAN: begin
        cmd = stp_pkg::CMD_SCAN;
        if (sts.hit || sts.last) begin
          state_nxt = S_FINISH;
        end
      end
      S_CHK: begin
        cmd       = stp_pkg::CMD_CHECK;
        state_nxt = S_FINISH;
      end
      S_TICK: begin
        cmd = stp_pkg::CMD_TICK;
        if (sts.last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd           = stp_pkg::CMD_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/stp_dp.sv
`default_nettype none
module stp_dp #(
  parameter int SLOTS = stp_pkg::SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire stp_pkg::cmd_t                  cmd,
  output stp_pkg::sts_t                       sts,
  input  wire logic [stp_pkg::ACT_W-1:0]      in_action,
  input  wire logic [stp_pkg::ID_W-1:0]       in_timer_id,
  input  wire logic [stp_pkg::TICKS_W-1:0]    in_ticks,
  output logic                                out_ok,
  output logic [stp_pkg::HANDLE_W-1:0]        out_handle,
  output logic [stp_pkg::STATUS_W-1:0]        out_status
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [stp_pkg::TICKS_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]            in_use_r;

  logic [stp_pkg::ACT_W-1:0]   act_r;
  logic [stp_pkg::ID_W-1:0]    id_r;
  logic [stp_pkg::TICKS_W-1:0] ticks_r;
  logic [IDX_W-1:0]            cnt_r;
  logic [stp_pkg::TICKS_W-1:0] rdata_r;
  logic                        wb_vld_r;
  logic [IDX_W-1:0]            wb_addr_r;

  logic                        res_ok_r;
  logic [stp_pkg::HANDLE_W-1:0] res_handle_r;
  logic [stp_pkg::STATUS_W-1:0] res_status_r;
  logic                        out_ok_r;
  logic [stp_pkg::HANDLE_W-1:0] out_handle_r;
  logic [stp_pkg::STATUS_W-1:0] out_status_r;

  logic                        id_in_range;
  logic [IDX_W-1:0]            id_addr;
  logic                        live;
  logic                        cnt_last;
  logic                        cnt_free;
  logic [IDX_W-1:0]            rd_addr;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_wa;
  logic [stp_pkg::TICKS_W-1:0] mem_wd;

  assign id_in_range = (32'(id_r) < 32'(SLOTS));
  assign id_addr     = id_in_range ? IDX_W'(id_r) : '0;
  assign live        = id_in_range && (id_r != '0) && in_use_r[id_addr];
  assign cnt_last    = (32'(cnt_r) == 32'(SLOTS - 1));
  assign cnt_free    = !in_use_r[cnt_r];

  assign sts.act  = act_r;
  assign sts.hit  = cnt_free;
  assign sts.last = cnt_last;

  assign out_ok     = out_ok_r;
  assign out_handle = out_handle_r;
  assign out_status = out_status_r;

  always_comb begin
    rd_addr = '0;
    if (cmd == stp_pkg::CMD_EXEC) begin
      rd_addr = id_addr;
    end else if (cmd == stp_pkg::CMD_TICK) begin
      rd_addr = cnt_r;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_r;
    mem_wd = ticks_r;
    if (wb_vld_r) begin
      mem_we = in_use_r[wb_addr_r] && (rdata_r != '0);
      mem_wa = wb_addr_r;
      mem_wd = rdata_r - stp_pkg::TICKS_W'(1);
    end else if (cmd == stp_pkg::CMD_SCAN) begin
      mem_we = cnt_free;
    end else if (cmd == stp_pkg::CMD_EXEC && act_r == stp_pkg::ACT_RELOAD) begin
      mem_we = live;
      mem_wa = id_addr;
    end
  end

  // count store, one write and one read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      wb_vld_r <= 1'b0;
    end else begin
      wb_vld_r <= (cmd == stp_pkg::CMD_TICK);
      if (cmd == stp_pkg::CMD_EXEC) begin
        if (act_r == stp_pkg::ACT_RELEASE && live) begin
          in_use_r[id_addr] <= 1'b0;
        end else if (act_r == stp_pkg::ACT_CLEAR) begin
          in_use_r <= '0;
        end
      end else if (cmd == stp_pkg::CMD_SCAN && cnt_free) begin
        in_use_r[cnt_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= cnt_r;
    case (cmd)
      stp_pkg::CMD_LOAD: begin
        act_r   <= in_action;
        id_r    <= in_timer_id;
        ticks_r <= in_ticks;
      end
      stp_pkg::CMD_EXEC: begin
        cnt_r        <= IDX_W'(1);
        res_handle_r <= '0;
        res_status_r <= stp_pkg::ST_COUNTING;
        case (act_r)
          stp_pkg::ACT_RELOAD, stp_pkg::ACT_RELEASE: res_ok_r <= live;
          stp_pkg::ACT_TICK, stp_pkg::ACT_CLEAR:     res_ok_r <= 1'b1;
          default:                                   res_ok_r <= 1'b0;
        endcase
      end
      stp_pkg::CMD_SCAN: begin
        if (cnt_free) begin
          res_ok_r     <= 1'b1;
          res_handle_r <= stp_pkg::HANDLE_W'(cnt_r);
        end else if (!cnt_last) begin
          cnt_r <= cnt_r + IDX_W'(1);
        end
      end
      stp_pkg::CMD_CHECK: begin
        res_ok_r <= live;
        if (!live) begin
          res_status_r <= stp_pkg::ST_NONE;
        end else if (rdata_r != '0) begin
          res_status_r <= stp_pkg::ST_COUNTING;
        end else begin
          res_status_r <= stp_pkg::ST_EXPIRED;
        end
      end
      stp_pkg::CMD_TICK: begin
        if (!cnt_last) begin
          cnt_r <= cnt_r + IDX_W'(1);
        end
      end
      stp_pkg::CMD_PUBLISH: begin
        out_ok_r     <= res_ok_r;
        out_handle_r <= res_handle_r;
        out_status_r <= res_status_r;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/soft_timer_pool_top.sv
`default_nettype none
// pool of SLOTS countdown timers with handles 1 to SLOTS-1 (handle 0 is never
// given out). one result transaction per input transaction. request walks the
// slots from 1 for the lowest free one, and tick walks every slot from 1
// through the single count memory with one decrementer. a new transaction is
// taken only once the last one has been published. a finished result waits
// in the output register while the next transaction is taken. on a pool wider
// than 16 the handle carries its low 4 bits only.
module soft_timer_pool_top #(
  parameter int SLOTS = stp_pkg::SLOTS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // action [2:0], timer_id [6:3], ticks [38:7], zero [39]
  input  wire logic [stp_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // ok [0], handle [4:1], timer_status [6:5], zero [7]
  output logic [stp_pkg::OUT_TDATA_W-1:0]         out_tdata
);

  stp_pkg::cmd_t                 cmd;
  stp_pkg::sts_t                 sts;
  logic                          res_ok;
  logic [stp_pkg::HANDLE_W-1:0]  res_handle;
  logic [stp_pkg::STATUS_W-1:0]  res_status;

  stp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  stp_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_action   (in_tdata[2:0]),
    .in_timer_id (in_tdata[6:3]),
    .in_ticks    (in_tdata[38:7]),
    .out_ok      (res_ok),
    .out_handle  (res_handle),
    .out_status  (res_status)
  );

  assign out_tdata = {1'b0, res_status, res_handle, res_ok};

endmodule
`default_nettype wire

// File: test/tb_soft_timer_pool_top.sv
`timescale 1ns / 1ps
module tb_soft_timer_pool_top;
  import stp_pkg::*;

  localparam int POOL_SLOTS = SLOTS_DEF;
  localparam int CLK_HALF = 4;
  localparam int N_RANDOM = 700;
  localparam int CALM_FROM = 600;
  localparam int HOLD_AT = 100;
  localparam int PAUSE_AT = 300;
  localparam int LONG_HOLD = 250;
  localparam int DRAIN_WAIT = 40;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [ACT_W-1:0] ACT_BAD6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_BAD7 = 3'd7;

  // ok [0], handle [4:1], timer_status [6:5], zero [7]
  typedef struct packed {
    logic                pad;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
    logic                ok;
  } timer_reply_t;

  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic [ID_W-1:0]    id;
    logic [TICKS_W-1:0] ticks;
    logic [3:0]         reps;
    logic               typed;
    timer_reply_t       want;
  } dir_row_t;

  localparam timer_reply_t FAIL_REPLY = '0;
  localparam timer_reply_t OK_REPLY = '{1'b0, 2'b00, 4'd0, 1'b1};
  localparam timer_reply_t NONE_REPLY = '{1'b0, ST_NONE, 4'd0, 1'b0};

  localparam int N_DIR = 24;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{ACT_CHECK,   4'd0,  32'd0,          4'd1,  1'b1, NONE_REPLY},
    '{ACT_RELEASE, 4'd5,  32'd0,          4'd1,  1'b1, FAIL_REPLY},
    '{ACT_RELOAD,  4'd3,  32'd7,          4'd1,  1'b1, FAIL_REPLY},
    '{ACT_REQUEST, 4'd0,  32'd0,          4'd1,  1'b1, '{1'b0, 2'b00, 4'd1, 1'b1}},
    '{ACT_REQUEST, 4'd9,  32'hffff_ffff,  4'd1,  1'b1, '{1'b0, 2'b00, 4'd2, 1'b1}},
    '{ACT_REQUEST, 4'd15, 32'd2,          4'd1,  1'b1, '{1'b0, 2'b00, 4'd3, 1'b1}},
    '{ACT_CHECK,   4'd1,  32'd0,          4'd1,  1'b1, '{1'b0, ST_EXPIRED, 4'd0, 1'b1}},
    '{ACT_CHECK,   4'd2,  32'd0,          4'd1,  1'b1, '{1'b0, ST_COUNTING, 4'd0, 1'b1}},
    '{ACT_TICK,    4'd0,  32'd0,          4'd1,  1'b1, OK_REPLY},
    '{ACT_TICK,    4'd7,  32'hffff_ffff,  4'd1,  1'b1, OK_REPLY},
    '{ACT_CHECK,   4'd3,  32'd0,          4'd1,  1'b0, FAIL_REPLY},
    '{ACT_RELOAD,  4'd3,  32'd1,          4'd1,  1'b0, FAIL_REPLY},
    '{ACT_RELOAD,  4'd0,  32'd5,          4'd1,  1'b1, FAIL_REPLY},
    '{ACT_RELEASE, 4'd0,  32'd0,          4'd1,  1'b1, FAIL_REPLY},
    '{ACT_CHECK,   4'd9,  32'd0,          4'd1,  1'b1, NONE_REPLY},
    '{ACT_BAD6,    4'd15, 32'hffff_ffff,  4'd1,  1'b1, FAIL_REPLY},
    '{ACT_BAD7,    4'd10, 32'haaaa_aaaa,  4'd1,  1'b1, FAIL_REPLY},
    '{ACT_RELEASE, 4'd2,  32'd0,          4'd1,  1'b1, OK_REPLY},
    '{ACT_CHECK,   4'd2,  32'd0,          4'd1,  1'b1, NONE_REPLY},
    // fill every free slot, then the pool is full
    '{ACT_REQUEST, 4'd0,  32'h5555_5555,  4'd13, 1'b0, FAIL_REPLY},
    '{ACT_REQUEST, 4'd4,  32'd9,          4'd1,  1'b1, FAIL_REPLY},
    '{ACT_CHECK,   4'd15, 32'd0,          4'd1,  1'b0, FAIL_REPLY},
    '{ACT_CLEAR,   4'd0,  32'd0,          4'd1,  1'b1, OK_REPLY},
    '{ACT_CHECK,   4'd1,  32'd0,          4'd1,  1'b1, NONE_REPLY}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  bit pool_busy [POOL_SLOTS];
  bit [TICKS_W-1:0] pool_count [POOL_SLOTS];
  timer_reply_t pending_replies [$];
  timer_reply_t seen_reply, due_reply;
  int n_mismatch = 0;
  int n_cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  always #CLK_HALF clk = ~clk;

  soft_timer_pool_top #(
    .SLOTS(POOL_SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic bit slot_live(input logic [ID_W-1:0] id);
    return id != 0 && int'(id) < POOL_SLOTS && pool_busy[id];
  endfunction

  function automatic timer_reply_t pool_predict(input logic [ACT_W-1:0] act,
                                                input logic [ID_W-1:0] id,
                                                input logic [TICKS_W-1:0] ticks);
    timer_reply_t r;
    bit found;
    r = '0;
    found = 1'b0;
    case (act)
      ACT_REQUEST: begin
        for (int i = 1; i < POOL_SLOTS; i++) begin
          if (!found && !pool_busy[i]) begin
            found = 1'b1;
            pool_busy[i] = 1'b1;
            pool_count[i] = ticks;
            r.ok = 1'b1;
            r.handle = HANDLE_W'(i);
          end
        end
      end
      ACT_RELOAD: begin
        if (slot_live(id)) begin
          pool_count[id] = ticks;
          r.ok = 1'b1;
        end
      end
      ACT_RELEASE: begin
        if (slot_live(id)) begin
          pool_busy[id] = 1'b0;
          pool_count[id] = '0;
          r.ok = 1'b1;
        end
      end
      ACT_CHECK: begin
        if (slot_live(id)) begin
          r.ok = 1'b1;
          r.status = (pool_count[id] != 0) ? ST_COUNTING : ST_EXPIRED;
        end else begin
          r.status = ST_NONE;
        end
      end
      ACT_TICK: begin
        for (int i = 1; i < POOL_SLOTS; i++) begin
          if (pool_busy[i] && pool_count[i] != 0) pool_count[i] = pool_count[i] - 1;
        end
        r.ok = 1'b1;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < POOL_SLOTS; i++) begin
          pool_busy[i] = 1'b0;
          pool_count[i] = '0;
        end
        r.ok = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [ID_W-1:0] pick_handle();
    int start;
    int slot;
    start = $urandom_range(1, POOL_SLOTS - 1);
    for (int k = 0; k < POOL_SLOTS - 1; k++) begin
      slot = ((start - 1 + k) % (POOL_SLOTS - 1)) + 1;
      if (pool_busy[slot]) return ID_W'(slot);
    end
    return ID_W'($urandom_range(0, 15));
  endfunction

  task automatic flag_mismatch(input string what, input timer_reply_t want,
                               input timer_reply_t got);
    if (n_mismatch < 10)
      $display("mismatch (%s): expected ok=%0d handle=%0d status=%0d,",
               what, want.ok, want.handle, want.status,
               " got ok=%0d handle=%0d status=%0d", got.ok, got.handle, got.status);
    n_mismatch++;
  endtask

  task automatic send_timer_op(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                               input logic [TICKS_W-1:0] ticks, input bit typed,
                               input timer_reply_t want);
    timer_reply_t pred;
    in_tdata <= {1'b0, ticks, id, act};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = pool_predict(act, id, ticks);
    pending_replies.push_back(typed ? want : pred);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_reply = out_tdata;
      if (pending_replies.size() == 0) begin
        flag_mismatch("unexpected transaction", FAIL_REPLY, seen_reply);
      end else begin
        due_reply = pending_replies.pop_front();
        if (seen_reply.ok !== due_reply.ok || seen_reply.handle !== due_reply.handle ||
            seen_reply.status !== due_reply.status)
          flag_mismatch("field", due_reply, seen_reply);
      end
    end
  end

  initial begin : sink
    int stall;
    while (!rst_n) @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 11);
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : source
    int sel;
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0] id;
    logic [TICKS_W-1:0] ticks;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIR; r++) begin
      for (int k = 0; k < DIR_TAB[r].reps; k++)
        send_timer_op(DIR_TAB[r].act, DIR_TAB[r].id, DIR_TAB[r].ticks, DIR_TAB[r].typed,
                      DIR_TAB[r].want);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == CALM_FROM) calm = 1'b1;
      // let the pool drain completely once
      if (i == PAUSE_AT) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_replies.size() != 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 25) act = ACT_REQUEST;
      else if (sel < 40) act = ACT_RELOAD;
      else if (sel < 55) act = ACT_RELEASE;
      else if (sel < 75) act = ACT_CHECK;
      else if (sel < 92) act = ACT_TICK;
      else if (sel < 95) act = ACT_CLEAR;
      else if (sel < 98) act = ACT_BAD6;
      else act = ACT_BAD7;
      if ($urandom_range(0, 9) < 6) id = pick_handle();
      else id = $urandom_range(0, 15);
      sel = $urandom_range(0, 9);
      if (sel < 5) ticks = $urandom_range(0, 3);
      else if (sel < 8) ticks = $urandom_range(0, 40);
      else ticks = $urandom;
      send_timer_op(act, id, ticks, 1'b0, FAIL_REPLY);
    end

    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_mismatch == 0 && pending_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
